FILE: rtl/pcva_pkg.sv
// ----------------------------------------------------------------------------
// pcva_pkg
// Shared types, constants and the control store of the polar/rectangular
// vector accumulator: operation codes, microcode word layout, program and
// the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package pcva_pkg;

    localparam int OP_WIDTH   = 3;
    localparam int VAL_WIDTH  = 24;
    localparam int ANG_WIDTH  = 16;
    localparam int GUARD_BITS = 4;
    localparam int ZW         = 32;
    localparam int ATAN_DEPTH = 24;
    localparam int ATAN_IDX_W = 5;
    localparam int GAIN_WIDTH = 24;
    localparam int GAIN_FRAC  = 24;
    localparam int UADDR_W    = 5;

    localparam logic [GAIN_WIDTH-1:0] CORDIC_GAIN = 24'd10187762;

    localparam logic [OP_WIDTH-1:0] OP_ADD_POLAR = 3'd0;
    localparam logic [OP_WIDTH-1:0] OP_SET_X     = 3'd1;
    localparam logic [OP_WIDTH-1:0] OP_SET_Y     = 3'd2;
    localparam logic [OP_WIDTH-1:0] OP_SET_MAG   = 3'd3;
    localparam logic [OP_WIDTH-1:0] OP_SET_DIR   = 3'd4;

    typedef enum logic [3:0] {
        ACT_NOP,
        ACT_LOAD_X,
        ACT_LOAD_Y,
        ACT_LOAD_LEN,
        ACT_LOAD_HDG,
        ACT_MUL_LO,
        ACT_MUL_HI,
        ACT_ROT_INIT,
        ACT_ROT_STEP,
        ACT_ROT_ADD,
        ACT_ROT_STORE,
        ACT_VEC_INIT,
        ACT_VEC_STEP,
        ACT_VEC_FIN
    } act_t;

    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_GOTO,
        SEQ_LOOP,
        SEQ_IFZERO,
        SEQ_DONE
    } seq_t;

    typedef struct packed {
        act_t               act;
        logic               use_operand;
        logic               mul_cordic_x;
        seq_t               seq;
        logic [UADDR_W-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        logic vec_zero;
    } dp_status_t;

    // Control store addresses.
    localparam logic [UADDR_W-1:0] UA_ADD_MLO   = 5'd0;
    localparam logic [UADDR_W-1:0] UA_ADD_MHI   = 5'd1;
    localparam logic [UADDR_W-1:0] UA_ADD_RINIT = 5'd2;
    localparam logic [UADDR_W-1:0] UA_ADD_RSTEP = 5'd3;
    localparam logic [UADDR_W-1:0] UA_ADD_SUM   = 5'd4;
    localparam logic [UADDR_W-1:0] UA_VEC_INIT  = 5'd5;
    localparam logic [UADDR_W-1:0] UA_VEC_STEP  = 5'd6;
    localparam logic [UADDR_W-1:0] UA_VEC_MLO   = 5'd7;
    localparam logic [UADDR_W-1:0] UA_VEC_MHI   = 5'd8;
    localparam logic [UADDR_W-1:0] UA_VEC_FIN   = 5'd9;
    localparam logic [UADDR_W-1:0] UA_SET_X     = 5'd10;
    localparam logic [UADDR_W-1:0] UA_SET_Y     = 5'd11;
    localparam logic [UADDR_W-1:0] UA_SET_MAG   = 5'd12;
    localparam logic [UADDR_W-1:0] UA_SET_DIR   = 5'd13;
    localparam logic [UADDR_W-1:0] UA_ROT_MLO   = 5'd14;
    localparam logic [UADDR_W-1:0] UA_ROT_MHI   = 5'd15;
    localparam logic [UADDR_W-1:0] UA_ROT_INIT  = 5'd16;
    localparam logic [UADDR_W-1:0] UA_ROT_STEP  = 5'd17;
    localparam logic [UADDR_W-1:0] UA_ROT_STORE = 5'd18;
    localparam logic [UADDR_W-1:0] UA_FINISH    = 5'd19;

    function automatic ctrl_word_t uw(input act_t act, input logic use_op,
                                      input logic mul_x, input seq_t seq,
                                      input logic [UADDR_W-1:0] target);
        ctrl_word_t w;
        w.act          = act;
        w.use_operand  = use_op;
        w.mul_cordic_x = mul_x;
        w.seq          = seq;
        w.target       = target;
        return w;
    endfunction

    function automatic ctrl_word_t ucode_word(input logic [UADDR_W-1:0] addr);
        ctrl_word_t w;
        case (addr)
            // Add a polar vector: rotate the operand, sum, then vector.
            UA_ADD_MLO:   w = uw(ACT_MUL_LO,    1'b1, 1'b0, SEQ_NEXT,   UA_FINISH);
            UA_ADD_MHI:   w = uw(ACT_MUL_HI,    1'b1, 1'b0, SEQ_NEXT,   UA_FINISH);
            UA_ADD_RINIT: w = uw(ACT_ROT_INIT,  1'b1, 1'b0, SEQ_NEXT,   UA_FINISH);
            UA_ADD_RSTEP: w = uw(ACT_ROT_STEP,  1'b1, 1'b0, SEQ_LOOP,   UA_ADD_RSTEP);
            UA_ADD_SUM:   w = uw(ACT_ROT_ADD,   1'b1, 1'b0, SEQ_NEXT,   UA_FINISH);
            // Vectoring pass shared by add, set x and set y.
            UA_VEC_INIT:  w = uw(ACT_VEC_INIT,  1'b0, 1'b0, SEQ_IFZERO, UA_FINISH);
            UA_VEC_STEP:  w = uw(ACT_VEC_STEP,  1'b0, 1'b0, SEQ_LOOP,   UA_VEC_STEP);
            UA_VEC_MLO:   w = uw(ACT_MUL_LO,    1'b0, 1'b1, SEQ_NEXT,   UA_FINISH);
            UA_VEC_MHI:   w = uw(ACT_MUL_HI,    1'b0, 1'b1, SEQ_NEXT,   UA_FINISH);
            UA_VEC_FIN:   w = uw(ACT_VEC_FIN,   1'b0, 1'b0, SEQ_GOTO,   UA_FINISH);
            UA_SET_X:     w = uw(ACT_LOAD_X,    1'b0, 1'b0, SEQ_GOTO,   UA_VEC_INIT);
            UA_SET_Y:     w = uw(ACT_LOAD_Y,    1'b0, 1'b0, SEQ_GOTO,   UA_VEC_INIT);
            UA_SET_MAG:   w = uw(ACT_LOAD_LEN,  1'b0, 1'b0, SEQ_GOTO,   UA_ROT_MLO);
            UA_SET_DIR:   w = uw(ACT_LOAD_HDG,  1'b0, 1'b0, SEQ_NEXT,   UA_FINISH);
            // Rotation pass from the stored magnitude and direction.
            UA_ROT_MLO:   w = uw(ACT_MUL_LO,    1'b0, 1'b0, SEQ_NEXT,   UA_FINISH);
            UA_ROT_MHI:   w = uw(ACT_MUL_HI,    1'b0, 1'b0, SEQ_NEXT,   UA_FINISH);
            UA_ROT_INIT:  w = uw(ACT_ROT_INIT,  1'b0, 1'b0, SEQ_NEXT,   UA_FINISH);
            UA_ROT_STEP:  w = uw(ACT_ROT_STEP,  1'b0, 1'b0, SEQ_LOOP,   UA_ROT_STEP);
            UA_ROT_STORE: w = uw(ACT_ROT_STORE, 1'b0, 1'b0, SEQ_NEXT,   UA_FINISH);
            UA_FINISH:    w = uw(ACT_NOP,       1'b0, 1'b0, SEQ_DONE,   UA_FINISH);
            default:      w = uw(ACT_NOP,       1'b0, 1'b0, SEQ_DONE,   UA_FINISH);
        endcase
        return w;
    endfunction

    function automatic logic [UADDR_W-1:0] dispatch_addr(input logic [OP_WIDTH-1:0] op);
        logic [UADDR_W-1:0] a;
        case (op)
            OP_ADD_POLAR: a = UA_ADD_MLO;
            OP_SET_X:     a = UA_SET_X;
            OP_SET_Y:     a = UA_SET_Y;
            OP_SET_MAG:   a = UA_SET_MAG;
            OP_SET_DIR:   a = UA_SET_DIR;
            default:      a = UA_FINISH;
        endcase
        return a;
    endfunction

    // atan(2^-i) as a 32-bit binary angle.
    function automatic logic [ZW-1:0] atan_angle(input logic [ATAN_IDX_W-1:0] idx);
        logic [ZW-1:0] a;
        case (idx)
            5'd0:    a = 32'h2000_0000;
            5'd1:    a = 32'h12E4_051E;
            5'd2:    a = 32'h09FB_385B;
            5'd3:    a = 32'h0511_11D4;
            5'd4:    a = 32'h028B_0D43;
            5'd5:    a = 32'h0145_D7E1;
            5'd6:    a = 32'h00A2_F61E;
            5'd7:    a = 32'h0051_7C55;
            5'd8:    a = 32'h0028_BE53;
            5'd9:    a = 32'h0014_5F2F;
            5'd10:   a = 32'h000A_2F98;
            5'd11:   a = 32'h0005_17CC;
            5'd12:   a = 32'h0002_8BE6;
            5'd13:   a = 32'h0001_45F3;
            5'd14:   a = 32'h0000_A2FA;
            5'd15:   a = 32'h0000_517D;
            5'd16:   a = 32'h0000_28BE;
            5'd17:   a = 32'h0000_145F;
            5'd18:   a = 32'h0000_0A30;
            5'd19:   a = 32'h0000_0518;
            5'd20:   a = 32'h0000_028C;
            5'd21:   a = 32'h0000_0146;
            5'd22:   a = 32'h0000_00A3;
            5'd23:   a = 32'h0000_0051;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

FILE: rtl/polar_cartesian_vector_accumulator_unit.sv
// With N = CORDIC_STEPS (capped at 24), each pass of the single shared CORDIC
// stage runs N iterations: add makes a rotation and a vectoring pass, set x/y a
// vectoring pass and set magnitude/direction a rotation pass; unused codes do no
// work, and a vectoring pass that meets the zero vector skips its iterations. One beat is
// in work at a time; s_ready returns at the edge that registers the result.
// Synchronous active-low reset zeroes the vector and empties the output register.
// ----------------------------------------------------------------------------
// polar_cartesian_vector_accumulator_unit
// Keeps one 2-D vector in rectangular and polar form and recomputes the other
// form after each operation with a microcoded CORDIC datapath.
// ----------------------------------------------------------------------------
module polar_cartesian_vector_accumulator_unit import pcva_pkg::*; #(
    parameter int CORDIC_STEPS = 16,
    parameter int COORD_WIDTH  = 24
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [OP_WIDTH-1:0]         s_operation,
    input  logic signed [VAL_WIDTH-1:0] s_operand_value,
    input  logic [ANG_WIDTH-1:0]        s_operand_angle,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [VAL_WIDTH-1:0] m_x_out,
    output logic signed [VAL_WIDTH-1:0] m_y_out,
    output logic signed [VAL_WIDTH-1:0] m_magnitude_out,
    output logic [ANG_WIDTH-1:0]        m_direction_out
);

    localparam int NSTEPS = (CORDIC_STEPS > ATAN_DEPTH) ? ATAN_DEPTH : CORDIC_STEPS;
    localparam int ITER_W = $clog2(NSTEPS);
    localparam int OW     = (COORD_WIDTH > VAL_WIDTH) ? COORD_WIDTH : VAL_WIDTH;

    logic                          accept;
    logic                          busy;
    logic                          finish;
    logic                          out_free;
    ctrl_word_t                    ctrl;
    dp_status_t                    status;
    logic [ITER_W-1:0]             iter;
    logic signed [COORD_WIDTH-1:0] x_value, y_value, len_value;
    logic [ANG_WIDTH-1:0]          hdg_value;
    logic signed [OW-1:0]          x_ext, y_ext, len_ext;

    logic                        m_valid_reg, m_valid_next;
    logic signed [VAL_WIDTH-1:0] m_x_reg, m_y_reg, m_mag_reg;
    logic [ANG_WIDTH-1:0]        m_dir_reg;

    assign s_ready  = !busy;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    pcva_useq #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_useq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .operation (s_operation),
        .out_free  (out_free),
        .status    (status),
        .ctrl      (ctrl),
        .iter      (iter),
        .busy      (busy),
        .finish    (finish)
    );

    pcva_dpath #(
        .CORDIC_STEPS(CORDIC_STEPS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (accept),
        .operand_value (s_operand_value),
        .operand_angle (s_operand_angle),
        .ctrl          (ctrl),
        .iter          (iter),
        .status        (status),
        .x_value       (x_value),
        .y_value       (y_value),
        .len_value     (len_value),
        .hdg_value     (hdg_value)
    );

    assign x_ext   = OW'(x_value);
    assign y_ext   = OW'(y_value);
    assign len_ext = OW'(len_value);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_x_reg   <= x_ext[VAL_WIDTH-1:0];
            m_y_reg   <= y_ext[VAL_WIDTH-1:0];
            m_mag_reg <= len_ext[VAL_WIDTH-1:0];
            m_dir_reg <= hdg_value;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_x_out         = m_x_reg;
    assign m_y_out         = m_y_reg;
    assign m_magnitude_out = m_mag_reg;
    assign m_direction_out = m_dir_reg;

endmodule

FILE: rtl/pcva_useq.sv
// ----------------------------------------------------------------------------
// pcva_useq
// Microcode sequencer: program counter, iteration counter and control store.
// Dispatches on the operation of an accepted beat and walks its program.
// ----------------------------------------------------------------------------
module pcva_useq import pcva_pkg::*; #(
    parameter int CORDIC_STEPS = 16,
    localparam int NSTEPS = (CORDIC_STEPS > ATAN_DEPTH) ? ATAN_DEPTH : CORDIC_STEPS,
    localparam int ITER_W = $clog2(NSTEPS)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [OP_WIDTH-1:0] operation,
    input  logic                out_free,
    input  dp_status_t          status,
    output ctrl_word_t          ctrl,
    output logic [ITER_W-1:0]   iter,
    output logic                busy,
    output logic                finish
);

    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(NSTEPS - 1);

    logic [UADDR_W-1:0] pc_reg, pc_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic               busy_reg, busy_next;
    ctrl_word_t         uword;

    assign uword = ucode_word(pc_reg);

    always_comb begin
        ctrl = uword;
        if (!busy_reg) begin
            ctrl.act = ACT_NOP;
        end
    end

    always_comb begin
        pc_next   = pc_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        finish    = 1'b0;
        if (!busy_reg) begin
            if (start) begin
                pc_next   = dispatch_addr(operation);
                iter_next = '0;
                busy_next = 1'b1;
            end
        end else begin
            case (uword.seq)
                SEQ_NEXT: begin
                    pc_next = pc_reg + UADDR_W'(1);
                end
                SEQ_GOTO: begin
                    pc_next = uword.target;
                end
                SEQ_LOOP: begin
                    if (iter_reg == ITER_LAST) begin
                        iter_next = '0;
                        pc_next   = pc_reg + UADDR_W'(1);
                    end else begin
                        iter_next = iter_reg + ITER_W'(1);
                        pc_next   = uword.target;
                    end
                end
                SEQ_IFZERO: begin
                    pc_next = status.vec_zero ? uword.target : pc_reg + UADDR_W'(1);
                end
                SEQ_DONE: begin
                    // Hold here until the output register can take the result.
                    if (out_free) begin
                        finish    = 1'b1;
                        busy_next = 1'b0;
                    end
                end
                default: begin
                    pc_next = UA_FINISH;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg   <= UA_FINISH;
            iter_reg <= '0;
            busy_reg <= 1'b0;
        end else begin
            pc_reg   <= pc_next;
            iter_reg <= iter_next;
            busy_reg <= busy_next;
        end
    end

    assign iter = iter_reg;
    assign busy = busy_reg;

endmodule

FILE: rtl/pcva_dpath.sv
// ----------------------------------------------------------------------------
// pcva_dpath
// Datapath: the vector state in both forms, one shared CORDIC stage, a
// two-pass gain multiplier and the rounding and saturation logic.
// ----------------------------------------------------------------------------
module pcva_dpath import pcva_pkg::*; #(
    parameter int CORDIC_STEPS = 16,
    parameter int COORD_WIDTH  = 24,
    localparam int NSTEPS = (CORDIC_STEPS > ATAN_DEPTH) ? ATAN_DEPTH : CORDIC_STEPS,
    localparam int ITER_W = $clog2(NSTEPS)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  logic signed [VAL_WIDTH-1:0]   operand_value,
    input  logic [ANG_WIDTH-1:0]          operand_angle,
    input  ctrl_word_t                    ctrl,
    input  logic [ITER_W-1:0]             iter,
    output dp_status_t                    status,
    output logic signed [COORD_WIDTH-1:0] x_value,
    output logic signed [COORD_WIDTH-1:0] y_value,
    output logic signed [COORD_WIDTH-1:0] len_value,
    output logic [ANG_WIDTH-1:0]          hdg_value
);

    localparam int W         = COORD_WIDTH;
    // Guard bits plus headroom for the CORDIC gain and the diagonal.
    localparam int DW        = W + GUARD_BITS + 3;
    localparam int PW        = DW + GAIN_WIDTH + 1;
    localparam int SATW      = ((W > VAL_WIDTH) ? W : VAL_WIDTH) + 8;
    localparam int MUL_SPLIT = 20;
    localparam int ROT_SHIFT = GAIN_FRAC - GUARD_BITS;
    localparam int VEC_SHIFT = GAIN_FRAC + GUARD_BITS;

    localparam logic signed [SATW-1:0] SAT_HI  = SATW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [SATW-1:0] SAT_LO  = ~SAT_HI;
    localparam logic signed [DW-1:0]   ROT_RND = DW'(64'd1 << (GUARD_BITS - 1));
    localparam logic signed [PW-1:0]   VEC_RND = PW'(64'd1 << (VEC_SHIFT - 1));
    localparam logic [ZW-1:0]          HDG_RND = ZW'(64'd1 << (ZW - ANG_WIDTH - 1));
    localparam logic [ZW-1:0]          HALF_TURN = ZW'(64'd1 << (ZW - 1));

    function automatic logic signed [W-1:0] sat_coord(input logic signed [SATW-1:0] v);
        logic signed [W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[W-1:0];
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    logic signed [W-1:0]  x_value_reg, x_next;
    logic signed [W-1:0]  y_value_reg, y_next;
    logic signed [W-1:0]  len_value_reg, len_next;
    logic [ANG_WIDTH-1:0] hdg_value_reg, hdg_next;
    logic signed [W-1:0]  opv_reg, opv_next;
    logic [ANG_WIDTH-1:0] opa_reg, opa_next;
    logic signed [DW-1:0] cx_reg, cx_next;
    logic signed [DW-1:0] cy_reg, cy_next;
    logic [ZW-1:0]        cz_reg, cz_next;
    logic signed [PW-1:0] acc_reg, acc_next;

    logic signed [W-1:0]                         mag_sel;
    logic [ANG_WIDTH-1:0]                        ang_sel;
    logic signed [DW-1:0]                        mul_a;
    logic signed [MUL_SPLIT:0]                   mul_lo_op;
    logic signed [DW-MUL_SPLIT-1:0]              mul_hi_op;
    logic signed [GAIN_WIDTH:0]                  gain_s;
    logic signed [MUL_SPLIT+GAIN_WIDTH+1:0]      prod_lo;
    logic signed [DW-MUL_SPLIT+GAIN_WIDTH:0]     prod_hi;
    logic signed [DW-1:0]                        rot_x0;
    logic                                        quad_flip;
    logic signed [DW-1:0]                        dx, dy;
    logic [ZW-1:0]                               atan_i;
    logic                                        step_neg;
    logic signed [DW-1:0]                        rx, ry;
    logic signed [DW-1:0]                        vx0, vy0;
    logic                                        vec_zero;
    logic [ZW-1:0]                               hdg_round;

    assign opv_next = sat_coord(SATW'(operand_value));
    assign opa_next = operand_angle;

    assign mag_sel = ctrl.use_operand ? opv_reg : len_value_reg;
    assign ang_sel = ctrl.use_operand ? opa_reg : hdg_value_reg;

    // The gain product is formed in two passes: low part, then high part.
    assign mul_a     = ctrl.mul_cordic_x ? cx_reg : DW'(mag_sel);
    assign mul_lo_op = $signed({1'b0, mul_a[MUL_SPLIT-1:0]});
    assign mul_hi_op = $signed(mul_a[DW-1:MUL_SPLIT]);
    assign gain_s    = $signed({1'b0, CORDIC_GAIN});
    assign prod_lo   = mul_lo_op * gain_s;
    assign prod_hi   = mul_hi_op * gain_s;

    // Angles in the second and third quadrant start from the opposite half.
    assign rot_x0    = DW'(acc_reg >>> ROT_SHIFT);
    assign quad_flip = ang_sel[ANG_WIDTH-1] ^ ang_sel[ANG_WIDTH-2];

    assign dx       = cy_reg >>> iter;
    assign dy       = cx_reg >>> iter;
    assign atan_i   = atan_angle(ATAN_IDX_W'(iter));
    assign step_neg = (ctrl.act == ACT_ROT_STEP) ? !cz_reg[ZW-1] : cy_reg[DW-1];

    assign rx = (cx_reg + ROT_RND) >>> GUARD_BITS;
    assign ry = (cy_reg + ROT_RND) >>> GUARD_BITS;

    assign vx0      = DW'(x_value_reg) <<< GUARD_BITS;
    assign vy0      = DW'(y_value_reg) <<< GUARD_BITS;
    assign vec_zero = (x_value_reg == '0) && (y_value_reg == '0);

    assign hdg_round = cz_reg + HDG_RND;

    always_comb begin
        x_next   = x_value_reg;
        y_next   = y_value_reg;
        len_next = len_value_reg;
        hdg_next = hdg_value_reg;
        cx_next  = cx_reg;
        cy_next  = cy_reg;
        cz_next  = cz_reg;
        acc_next = acc_reg;
        case (ctrl.act)
            ACT_NOP: begin
            end
            ACT_LOAD_X: begin
                x_next = opv_reg;
            end
            ACT_LOAD_Y: begin
                y_next = opv_reg;
            end
            ACT_LOAD_LEN: begin
                len_next = opv_reg;
            end
            ACT_LOAD_HDG: begin
                hdg_next = opa_reg;
            end
            ACT_MUL_LO: begin
                acc_next = PW'(prod_lo);
            end
            ACT_MUL_HI: begin
                acc_next = acc_reg + (PW'(prod_hi) <<< MUL_SPLIT);
            end
            ACT_ROT_INIT: begin
                cx_next = quad_flip ? -rot_x0 : rot_x0;
                cy_next = '0;
                cz_next = {ang_sel[ANG_WIDTH-1] ^ quad_flip, ang_sel[ANG_WIDTH-2:0],
                           {(ZW-ANG_WIDTH){1'b0}}};
            end
            ACT_ROT_STEP, ACT_VEC_STEP: begin
                if (step_neg) begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    cz_next = cz_reg - atan_i;
                end else begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    cz_next = cz_reg + atan_i;
                end
            end
            ACT_ROT_ADD: begin
                // The rotated components saturate on their own before the sum.
                x_next = sat_coord(SATW'(x_value_reg) + SATW'(sat_coord(SATW'(rx))));
                y_next = sat_coord(SATW'(y_value_reg) + SATW'(sat_coord(SATW'(ry))));
            end
            ACT_ROT_STORE: begin
                x_next = sat_coord(SATW'(rx));
                y_next = sat_coord(SATW'(ry));
            end
            ACT_VEC_INIT: begin
                if (vec_zero) begin
                    len_next = '0;
                    hdg_next = '0;
                end
                // Fold the left half-plane onto the right one.
                if (x_value_reg[W-1]) begin
                    cx_next = -vx0;
                    cy_next = -vy0;
                    cz_next = HALF_TURN;
                end else begin
                    cx_next = vx0;
                    cy_next = vy0;
                    cz_next = '0;
                end
            end
            ACT_VEC_FIN: begin
                len_next = sat_coord(SATW'((acc_reg + VEC_RND) >>> VEC_SHIFT));
                hdg_next = hdg_round[ZW-1:ZW-ANG_WIDTH];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_value_reg   <= '0;
            y_value_reg   <= '0;
            len_value_reg <= '0;
            hdg_value_reg <= '0;
        end else begin
            x_value_reg   <= x_next;
            y_value_reg   <= y_next;
            len_value_reg <= len_next;
            hdg_value_reg <= hdg_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            opv_reg <= opv_next;
            opa_reg <= opa_next;
        end
        cx_reg  <= cx_next;
        cy_reg  <= cy_next;
        cz_reg  <= cz_next;
        acc_reg <= acc_next;
    end

    assign status.vec_zero = vec_zero;
    assign x_value         = x_value_reg;
    assign y_value         = y_value_reg;
    assign len_value       = len_value_reg;
    assign hdg_value       = hdg_value_reg;

endmodule

FILE: rtl/pcva_checker.sv
// ----------------------------------------------------------------------------
// pcva_checker
// Port-level checks of the vector accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module pcva_checker import pcva_pkg::*; (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic [OP_WIDTH-1:0]         s_operation,
    input logic signed [VAL_WIDTH-1:0] s_operand_value,
    input logic [ANG_WIDTH-1:0]        s_operand_angle,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic signed [VAL_WIDTH-1:0] m_x_out,
    input logic signed [VAL_WIDTH-1:0] m_y_out,
    input logic signed [VAL_WIDTH-1:0] m_magnitude_out,
    input logic [ANG_WIDTH-1:0]        m_direction_out
);

    // Reset leaves the block ready and with no result pending.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("block not idle after reset");

    // Only one beat is in work at a time.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a beat is in work");

    // A new result only appears at the end of work on an accepted beat.
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared without work in progress");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_x_out) && $stable(m_y_out)
            && $stable(m_magnitude_out) && $stable(m_direction_out))
        else $error("stalled result changed");

endmodule

bind polar_cartesian_vector_accumulator_unit pcva_checker u_pcva_checker (.*);

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the polar/rectangular vector accumulator. A short
// directed table (reset state, extremes, quadrant boundaries, the zero vector,
// unused codes) is followed by random beats. Every accepted beat is run
// through a bit-exact CORDIC predictor kept in this file. Each result beat is
// compared field by field with the oldest prediction, while both sides idle
// and stall at random, except in a calm tail at the end of the random beats.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pcva_pkg::*;

    localparam int CORDIC_STEPS = 16;
    localparam int COORD_WIDTH  = 24;
    localparam int STEPS        = (CORDIC_STEPS > ATAN_DEPTH) ? ATAN_DEPTH : CORDIC_STEPS;
    localparam int RANDOM_BEATS = 1430;
    localparam int CALM_TAIL    = 150;
    localparam int DRAIN_CYCLES = 60;
    localparam int PRINT_LIMIT  = 30;

    localparam logic [OP_WIDTH-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_WIDTH-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_WIDTH-1:0] OP_SPARE_7 = 3'd7;

    localparam longint COORD_MAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam longint GAIN      = longint'(CORDIC_GAIN);

    localparam logic signed [VAL_WIDTH-1:0] VAL_MAX = 24'sh7FFFFF;
    localparam logic signed [VAL_WIDTH-1:0] VAL_MIN = 24'sh800000;

    localparam longint ARCTAN_BAM [ATAN_DEPTH] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    typedef struct packed {
        logic signed [VAL_WIDTH-1:0] x;
        logic signed [VAL_WIDTH-1:0] y;
        logic signed [VAL_WIDTH-1:0] mag;
        logic [ANG_WIDTH-1:0]        dir;
    } vec_state_t;

    typedef struct {
        logic [OP_WIDTH-1:0]         op;
        logic signed [VAL_WIDTH-1:0] val;
        logic [ANG_WIDTH-1:0]        ang;
        bit                          pinned;
        vec_state_t                  want;
    } plan_row_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic [OP_WIDTH-1:0]         s_operation;
    logic signed [VAL_WIDTH-1:0] s_operand_value;
    logic [ANG_WIDTH-1:0]        s_operand_angle;
    logic                        m_valid;
    logic                        m_ready;
    logic signed [VAL_WIDTH-1:0] m_x_out;
    logic signed [VAL_WIDTH-1:0] m_y_out;
    logic signed [VAL_WIDTH-1:0] m_magnitude_out;
    logic [ANG_WIDTH-1:0]        m_direction_out;

    polar_cartesian_vector_accumulator_unit #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .COORD_WIDTH  (COORD_WIDTH)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_operand_value (s_operand_value),
        .s_operand_angle (s_operand_angle),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_x_out         (m_x_out),
        .m_y_out         (m_y_out),
        .m_magnitude_out (m_magnitude_out),
        .m_direction_out (m_direction_out)
    );

    // Predictor state: the vector as the block should hold it.
    longint               track_x, track_y, track_len;
    logic [ANG_WIDTH-1:0] track_hdg;

    vec_state_t  vector_q[$];
    plan_row_t   directed_plan[$];
    int unsigned beats_in, results_checked, mismatches;
    int unsigned adds_seen, sets_seen, spares_seen;
    bit          pin_on;
    vec_state_t  pin_want;
    bit          calm_tail;
    bit          tx_busy, rx_busy;
    int unsigned rx_stall_left;

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    initial begin
        #3_000_000;
        $display("Timeout with %0d results still pending", vector_q.size());
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    function automatic longint clamp_coord(input longint v);
        return (v > COORD_MAX) ? COORD_MAX : ((v < COORD_MIN) ? COORD_MIN : v);
    endfunction

    function automatic longint half_up_shift(input longint v, input int unsigned s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // Rotation mode: x and y from the held magnitude and direction.
    function automatic void polar_to_rect();
        logic [31:0] zu;
        longint      cx, cy, cz, dx, dy;
        zu = {track_hdg, 16'h0000};
        cx = (track_len * GAIN) >>> (GAIN_FRAC - GUARD_BITS);
        cy = 0;
        // Left half-plane: start from the opposite direction with x negated.
        if (track_hdg >= 16'h4000 && track_hdg < 16'hC000) begin
            cx = -cx;
            zu = zu - 32'h8000_0000;
        end
        cz = longint'($signed(zu));
        for (int i = 0; i < STEPS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cz >= 0) begin
                cx = cx - dx;
                cy = cy + dy;
                cz = cz - ARCTAN_BAM[i];
            end else begin
                cx = cx + dx;
                cy = cy - dy;
                cz = cz + ARCTAN_BAM[i];
            end
        end
        track_x = clamp_coord(half_up_shift(cx, GUARD_BITS));
        track_y = clamp_coord(half_up_shift(cy, GUARD_BITS));
    endfunction

    // Vectoring mode: magnitude and direction from the held x and y.
    function automatic void rect_to_polar();
        longint      cx, cy, cz, dx, dy;
        logic [63:0] rounded;
        if (track_x == 0 && track_y == 0) begin
            track_len = 0;
            track_hdg = '0;
            return;
        end
        cx = track_x <<< GUARD_BITS;
        cy = track_y <<< GUARD_BITS;
        cz = 0;
        if (cx < 0) begin
            cx = -cx;
            cy = -cy;
            cz = 64'sd2147483648;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy < 0) begin
                cx = cx - dx;
                cy = cy + dy;
                cz = cz - ARCTAN_BAM[i];
            end else begin
                cx = cx + dx;
                cy = cy - dy;
                cz = cz + ARCTAN_BAM[i];
            end
        end
        track_len = clamp_coord(half_up_shift(cx * GAIN, GAIN_FRAC + GUARD_BITS));
        rounded   = cz + 64'sh8000;
        track_hdg = rounded[31:16];
    endfunction

    function automatic vec_state_t apply_operation(input logic [OP_WIDTH-1:0] op,
                                                   input logic signed [VAL_WIDTH-1:0] val,
                                                   input logic [ANG_WIDTH-1:0] ang);
        longint               keep_x, keep_y, keep_len, operand;
        logic [ANG_WIDTH-1:0] keep_hdg;
        vec_state_t           r;
        operand = clamp_coord(longint'(val));
        case (op)
            OP_ADD_POLAR: begin
                keep_x    = track_x;
                keep_y    = track_y;
                keep_len  = track_len;
                keep_hdg  = track_hdg;
                track_len = operand;
                track_hdg = ang;
                polar_to_rect();
                track_x   = clamp_coord(keep_x + track_x);
                track_y   = clamp_coord(keep_y + track_y);
                track_len = keep_len;
                track_hdg = keep_hdg;
                rect_to_polar();
            end
            OP_SET_X: begin
                track_x = operand;
                rect_to_polar();
            end
            OP_SET_Y: begin
                track_y = operand;
                rect_to_polar();
            end
            OP_SET_MAG: begin
                track_len = operand;
                polar_to_rect();
            end
            OP_SET_DIR: begin
                track_hdg = ang;
                polar_to_rect();
            end
            default: ;
        endcase
        r.x   = track_x[VAL_WIDTH-1:0];
        r.y   = track_y[VAL_WIDTH-1:0];
        r.mag = track_len[VAL_WIDTH-1:0];
        r.dir = track_hdg;
        return r;
    endfunction

    // Both channels are sampled here, at the rising edge.
    always @(posedge aclk) begin : watch
        vec_state_t got, want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = '{m_x_out, m_y_out, m_magnitude_out, m_direction_out};
                if (vector_q.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing pending: %p", got));
                end else begin
                    want = vector_q.pop_front();
                    results_checked++;
                    if (got.x !== want.x)
                        report_mismatch($sformatf("result %0d x_out %0d, want %0d",
                                                  results_checked, got.x, want.x));
                    if (got.y !== want.y)
                        report_mismatch($sformatf("result %0d y_out %0d, want %0d",
                                                  results_checked, got.y, want.y));
                    if (got.mag !== want.mag)
                        report_mismatch($sformatf("result %0d magnitude_out %0d, want %0d",
                                                  results_checked, got.mag, want.mag));
                    if (got.dir !== want.dir)
                        report_mismatch($sformatf("result %0d direction_out 0x%04h, want 0x%04h",
                                                  results_checked, got.dir, want.dir));
                end
            end
            if (s_valid && s_ready) begin
                want = apply_operation(s_operation, s_operand_value, s_operand_angle);
                if (pin_on)
                    want = pin_want;
                vector_q.push_back(want);
                beats_in++;
                case (s_operation)
                    OP_ADD_POLAR:                               adds_seen++;
                    OP_SET_X, OP_SET_Y, OP_SET_MAG, OP_SET_DIR: sets_seen++;
                    default:                                    spares_seen++;
                endcase
            end
        end
    end

    // Result side: random stall bursts, re-armed each cycle at the falling edge.
    always @(negedge aclk) begin
        if (rx_stall_left > 0 && !calm_tail) begin
            m_ready <= 1'b0;
            rx_stall_left--;
        end else if (!calm_tail && rx_busy && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            rx_stall_left = $urandom_range(1, 13) - 1;
        end else begin
            m_ready <= 1'b1;
        end
        if ($urandom_range(0, 255) == 0)
            rx_busy = ~rx_busy;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic drive_beat(input logic [OP_WIDTH-1:0] op,
                              input logic signed [VAL_WIDTH-1:0] val,
                              input logic [ANG_WIDTH-1:0] ang,
                              input bit pinned, input vec_state_t want);
        int unsigned target;
        if (!calm_tail && tx_busy && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        pin_on          = pinned;
        pin_want        = want;
        s_valid         <= 1'b1;
        s_operation     <= op;
        s_operand_value <= val;
        s_operand_angle <= ang;
        target = beats_in + 1;
        do @(negedge aclk); while (beats_in != target);
    endtask

    function automatic void plan_row(input logic [OP_WIDTH-1:0] op,
                                     input logic signed [VAL_WIDTH-1:0] val,
                                     input logic [ANG_WIDTH-1:0] ang,
                                     input bit pinned = 1'b0,
                                     input vec_state_t want = '0);
        plan_row_t row;
        row.op     = op;
        row.val    = val;
        row.ang    = ang;
        row.pinned = pinned;
        row.want   = want;
        directed_plan.push_back(row);
    endfunction

    function automatic logic signed [VAL_WIDTH-1:0] pick_coord();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return VAL_WIDTH'($signed($urandom_range(0, 131072)) - 65536);
            4, 5:       return VAL_WIDTH'($signed($urandom_range(0, 2097152)) - 1048576);
            6:          return VAL_WIDTH'($signed($urandom_range(0, 32)) - 16);
            7:          return ($urandom_range(0, 1) != 0) ? VAL_MAX : VAL_MIN;
            default:    return raw[VAL_WIDTH-1:0];
        endcase
    endfunction

    function automatic logic [ANG_WIDTH-1:0] pick_angle();
        logic [ANG_WIDTH-1:0] corner;
        if ($urandom_range(0, 4) != 0)
            return ANG_WIDTH'($urandom_range(0, 65535));
        corner = ANG_WIDTH'($urandom_range(0, 3)) << 14;
        return corner + ANG_WIDTH'($signed($urandom_range(0, 4)) - 2);
    endfunction

    function automatic logic [OP_WIDTH-1:0] OP_OP_SPARE_PICK();
        case ($urandom_range(0, 2))
            0:       return OP_SPARE_5;
            1:       return OP_SPARE_6;
            default: return OP_SPARE_7;
        endcase
    endfunction

    function automatic logic [OP_WIDTH-1:0] pick_operation();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return OP_ADD_POLAR;
        if (roll < 53) return OP_SET_X;
        if (roll < 66) return OP_SET_Y;
        if (roll < 80) return OP_SET_MAG;
        if (roll < 95) return OP_SET_DIR;
        return OP_OP_SPARE_PICK();
    endfunction

    initial begin : stimulus
        logic [OP_WIDTH-1:0]         op;
        logic signed [VAL_WIDTH-1:0] val;
        logic [ANG_WIDTH-1:0]        ang;
        int unsigned                 worked;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_operation     = OP_ADD_POLAR;
        s_operand_value = '0;
        s_operand_angle = '0;
        m_ready         = 1'b0;
        track_x         = 0;
        track_y         = 0;
        track_len       = 0;
        track_hdg       = '0;
        pin_on          = 1'b0;
        pin_want        = '0;
        calm_tail       = 1'b0;
        tx_busy         = 1'b1;
        rx_busy         = 1'b1;
        rx_stall_left   = 0;

        // Reset state, unused codes, the zero vector and quadrant boundaries.
        plan_row(OP_SPARE_5, VAL_MIN, 16'hFFFF, 1'b1, '0);
        plan_row(OP_SPARE_7, VAL_MAX, 16'h0000, 1'b1, '0);
        plan_row(OP_SET_DIR, 24'sd0, 16'h4000, 1'b1, '{24'sd0, 24'sd0, 24'sd0, 16'h4000});
        plan_row(OP_SET_X, 24'sd0, 16'hFFFF, 1'b1, '0);
        plan_row(OP_SET_MAG, VAL_MAX, 16'h0000);
        plan_row(OP_SET_DIR, 24'sd0, 16'h4000);
        plan_row(OP_SET_DIR, 24'sd0, 16'hC000);
        plan_row(OP_SET_DIR, 24'sd0, 16'hBFFF);
        plan_row(OP_SET_DIR, 24'sd0, 16'hFFFF);
        plan_row(OP_SET_MAG, VAL_MIN, 16'h0000);
        plan_row(OP_SPARE_6, 24'sd1234, 16'h1234);
        plan_row(OP_SET_X, VAL_MAX, 16'h0000);
        plan_row(OP_SET_Y, VAL_MAX, 16'h0000);
        plan_row(OP_SET_X, VAL_MIN, 16'h0000);
        plan_row(OP_SET_Y, VAL_MIN, 16'h0000);
        plan_row(OP_ADD_POLAR, VAL_MAX, 16'h0000);
        plan_row(OP_ADD_POLAR, VAL_MIN, 16'h8000);
        plan_row(OP_SET_X, 24'sd0, 16'h0000);
        plan_row(OP_SET_Y, 24'sd0, 16'h0000, 1'b1, '0);
        plan_row(OP_ADD_POLAR, 24'sd4096, 16'h2000);
        plan_row(OP_ADD_POLAR, 24'sd1, 16'h0001);
        plan_row(OP_SET_DIR, 24'sd0, 16'h8000);
        plan_row(OP_SET_MAG, 24'sd4096, 16'h0000);
        plan_row(OP_ADD_POLAR, 24'sd0, 16'hFFFF);
        plan_row(OP_SET_Y, -24'sd1, 16'h0000);

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_plan[i])
            drive_beat(directed_plan[i].op, directed_plan[i].val, directed_plan[i].ang,
                       directed_plan[i].pinned, directed_plan[i].want);

        worked = 0;
        while (worked < RANDOM_BEATS) begin
            op  = pick_operation();
            val = pick_coord();
            ang = pick_angle();
            worked++;
            if (worked % 64 == 0)
                tx_busy = ($urandom_range(0, 2) != 0);
            calm_tail = (worked >= RANDOM_BEATS - CALM_TAIL);
            drive_beat(op, val, ang, 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (vector_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (vector_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", vector_q.size()));

        $display("Drove %0d beats: %0d polar adds, %0d coordinate/polar sets, %0d unused codes",
                 beats_in, adds_seen, sets_seen, spares_seen);
        $display("Checked %0d result beats, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
